### hw/rtl/full_linear_convolution_unit_assert.svh
// Assertion macros for the convolution unit.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef FULL_LINEAR_CONVOLUTION_UNIT_ASSERT_SVH
`define FULL_LINEAR_CONVOLUTION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FLC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define FLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FLC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define FLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### hw/rtl/flc_pkg.sv
// Shared constants, types and state codes of the convolution unit.
// No dependencies; compiled first.
package flc_pkg;
  localparam int MAX_TAPS  = 64;
  localparam int TAP_W     = 18;
  localparam int SAMPLE_W  = 32;
  localparam int TAP_IN_W  = 18;
  localparam int TIDX_IN_W = 6;
  localparam int COUNT_W   = 7;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W     = $clog2(MAX_TAPS + 1);
  localparam int PROD_W    = SAMPLE_W + TAP_W;
  localparam int ACC_W     = PROD_W + $clog2(MAX_TAPS);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TAP_IN_W-1:0] tap_in_t;
  typedef logic signed [TAP_W-1:0]    tap_t;
  typedef logic [TIDX_IN_W-1:0]       tidx_in_t;
  typedef logic [COUNT_W-1:0]         cfg_count_t;
  typedef logic [IDX_W-1:0]           addr_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [QPTR_W-1:0]          qptr_t;
  typedef logic [QCNT_W-1:0]          qcnt_t;

  typedef enum logic {
    OP_TAP    = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAC,
    BK_DRAIN
  } bk_state_t;

  typedef struct packed {
    logic    is_sample;
    logic    tap_ok;
    addr_t   addr;
    tap_t    tap;
    sample_t sample;
    logic    last;
  } q_entry_t;

  localparam sample_t SAT_MAX = sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
  localparam sample_t SAT_MIN = sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}});
endpackage

### hw/rtl/flc_if.sv
// Valid/ready channel interfaces: input items, results and configuration.
// Depends on flc_pkg.
interface flc_item_if;
  import flc_pkg::*;
  logic     valid;
  logic     ready;
  op_t      opcode;
  tidx_in_t tap_index;
  tap_in_t  tap_value;
  sample_t  sample;
  logic     last_sample;
  modport source (output valid, opcode, tap_index, tap_value, sample, last_sample,
                  input ready);
  modport sink (input valid, opcode, tap_index, tap_value, sample, last_sample,
                output ready);
endinterface

interface flc_result_if;
  import flc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t conv_value;
  logic    saturated;
  logic    last_output;
  modport source (output valid, conv_value, saturated, last_output, input ready);
  modport sink (input valid, conv_value, saturated, last_output, output ready);
endinterface

interface flc_cfg_if;
  import flc_pkg::*;
  logic       valid;
  logic       ready;
  cfg_count_t tap_count;
  modport source (output valid, tap_count, input ready);
  modport sink (input valid, tap_count, output ready);
endinterface

### hw/rtl/flc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module flc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### hw/rtl/flc_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on flc_pkg and flc_item_if.
module flc_front (
  input  logic              clk,
  input  logic              rst,
  flc_item_if.sink          item,
  output logic              q_valid,
  input  logic              q_ready,
  output flc_pkg::q_entry_t q_entry
);
  import flc_pkg::*;

  q_entry_t slots [QDEPTH];
  q_entry_t incoming;
  qptr_t    wptr;
  qptr_t    rptr;
  qcnt_t    count;
  logic     push;
  logic     pop;

  function automatic qptr_t qptr_inc(qptr_t p);
    return (p == qptr_t'(QDEPTH - 1)) ? '0 : p + qptr_t'(1);
  endfunction

  always_comb begin
    incoming.is_sample = (item.opcode == OP_SAMPLE);
    incoming.tap_ok    = (int'(item.tap_index) < MAX_TAPS);
    incoming.addr      = addr_t'(item.tap_index);
    incoming.tap       = tap_t'(item.tap_value);
    incoming.sample    = item.sample;
    incoming.last      = item.last_sample;
  end

  assign item.ready = (count != qcnt_t'(QDEPTH));
  assign q_valid    = (count != '0);
  assign q_entry    = slots[rptr];
  assign push       = item.valid && item.ready;
  assign pop        = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= qptr_inc(wptr);
      end
      if (pop) begin
        rptr <= qptr_inc(rptr);
      end
      if (push && !pop) begin
        count <= count + qcnt_t'(1);
      end else if (pop && !push) begin
        count <= count - qcnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= incoming;
    end
  end
endmodule

### hw/rtl/flc_back.sv
// Back end: tap memory, circular delay line and one shared multiply-accumulate unit.
// Depends on flc_pkg, flc_ram and flc_result_if.
module flc_back (
  input  logic                clk,
  input  logic                rst,
  input  flc_pkg::cfg_count_t tap_count,
  input  logic                q_valid,
  output logic                q_ready,
  input  flc_pkg::q_entry_t   q_entry,
  flc_result_if.source        result
);
  import flc_pkg::*;

  localparam int HI_LSB = FRAC_BITS + SAMPLE_W - 1;

  bk_state_t            state;
  bk_state_t            state_next;
  addr_t                head;
  addr_t                head_inc;
  addr_t                dptr;
  cnt_t                 k;
  cnt_t                 n_act;
  cnt_t                 n_cfg;
  cnt_t                 flush;
  logic                 last_q;
  logic [MAX_TAPS-1:0]  dvalid;
  logic                 dvld_q;
  logic                 s1;
  logic                 s2;
  tap_t                 tap_rd;
  sample_t              dly_rd;
  sample_t              dly_eff;
  prod_t                prod;
  acc_t                 acc;
  logic [ACC_W-1-HI_LSB:0] acc_hi;
  logic                 fits;
  sample_t              sat_val;
  logic                 out_valid;
  logic                 out_free;
  sample_t              out_value;
  logic                 out_sat;
  logic                 out_last;
  logic                 start_sample;
  logic                 tap_we;
  logic                 issue;
  logic                 load_out;
  logic                 shift_zero;
  logic                 clr_all;

  function automatic addr_t addr_inc(addr_t a);
    return (a == addr_t'(MAX_TAPS - 1)) ? '0 : a + addr_t'(1);
  endfunction

  function automatic addr_t addr_dec(addr_t a);
    return (a == '0) ? addr_t'(MAX_TAPS - 1) : a - addr_t'(1);
  endfunction

  always_comb begin
    if (tap_count == '0) begin
      n_cfg = cnt_t'(1);
    end else if (int'(tap_count) > MAX_TAPS) begin
      n_cfg = cnt_t'(MAX_TAPS);
    end else begin
      n_cfg = cnt_t'(tap_count);
    end
  end

  assign head_inc = addr_inc(head);
  assign out_free = !out_valid || result.ready;

  always_comb begin
    state_next   = state;
    q_ready      = 1'b0;
    start_sample = 1'b0;
    tap_we       = 1'b0;
    issue        = 1'b0;
    load_out     = 1'b0;
    shift_zero   = 1'b0;
    clr_all      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_entry.is_sample) begin
            start_sample = 1'b1;
            state_next   = BK_MAC;
          end else begin
            tap_we = q_entry.tap_ok;
          end
        end
      end
      BK_MAC: begin
        issue = 1'b1;
        if (k == n_act - cnt_t'(1)) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!s1 && !s2 && out_free) begin
          load_out = 1'b1;
          if (last_q && (flush != n_act)) begin
            shift_zero = 1'b1;
            state_next = BK_MAC;
          end else begin
            clr_all    = last_q;
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  flc_ram #(.WIDTH(TAP_W), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (q_entry.addr),
    .wdata (q_entry.tap),
    .re    (issue),
    .raddr (k[IDX_W-1:0]),
    .rdata (tap_rd)
  );

  flc_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_dly_ram (
    .clk   (clk),
    .we    (start_sample),
    .waddr (head_inc),
    .wdata (q_entry.sample),
    .re    (issue),
    .raddr (dptr),
    .rdata (dly_rd)
  );

  assign dly_eff = dvld_q ? dly_rd : '0;
  assign acc_hi  = acc[ACC_W-1:HI_LSB];
  assign fits    = (&acc_hi) || !(|acc_hi);
  assign sat_val = fits ? sample_t'(acc[HI_LSB:FRAC_BITS]) :
                          (acc[ACC_W-1] ? SAT_MIN : SAT_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      dvalid    <= '0;
      s1        <= 1'b0;
      s2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1 <= issue;
      s2 <= s1;
      if (start_sample || shift_zero) begin
        head <= head_inc;
      end
      if (clr_all) begin
        dvalid <= '0;
      end else if (start_sample) begin
        dvalid[head_inc] <= 1'b1;
      end else if (shift_zero) begin
        dvalid[head_inc] <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_sample) begin
      n_act  <= n_cfg;
      last_q <= q_entry.last;
      flush  <= cnt_t'(1);
    end else if (shift_zero) begin
      flush <= flush + cnt_t'(1);
    end
    if (start_sample || shift_zero) begin
      k    <= '0;
      dptr <= head_inc;
    end else if (issue) begin
      k    <= k + cnt_t'(1);
      dptr <= addr_dec(dptr);
    end
    if (issue) begin
      dvld_q <= dvalid[dptr];
    end
    if (s1) begin
      prod <= dly_eff * tap_rd;
    end
    if (start_sample || shift_zero) begin
      acc <= '0;
    end else if (s2) begin
      acc <= acc + acc_t'(prod);
    end
    if (load_out) begin
      out_value <= sat_val;
      out_sat   <= !fits;
      out_last  <= last_q && (flush == n_act);
    end
  end

  assign result.valid       = out_valid;
  assign result.conv_value  = out_value;
  assign result.saturated   = out_sat;
  assign result.last_output = out_last;
endmodule

### hw/rtl/full_linear_convolution_unit.sv
// Full linear convolution of a Q16.16 sample stream with a loaded Q2.16 kernel of
// up to 64 taps. A tap-load item is queued and written to the tap memory while the
// back end is idle. A sample item with N active taps (tap_count, clamped to 1..64)
// gives one output; a last sample adds N - 1 tail outputs, then clears the delay
// line at once. The single multiply-accumulate unit reads one tap and one delayed
// sample per cycle from the tap and delay memories, and each output waits for the
// read/multiply/accumulate pipeline to drain. A two-entry queue sits between input
// and back end, and a result register lets the next output be computed while one
// waits to be taken.
`include "full_linear_convolution_unit_assert.svh"
module full_linear_convolution_unit (
  input logic          clk,
  input logic          rst,
  flc_item_if.sink     item,
  flc_result_if.source result,
  flc_cfg_if.sink      cfg
);
  import flc_pkg::*;

  cfg_count_t tap_count;
  logic       q_valid;
  logic       q_ready;
  q_entry_t   q_entry;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= cfg_count_t'(1);
    end else if (cfg.valid && cfg.ready) begin
      tap_count <= cfg.tap_count;
    end
  end

  flc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry)
  );

  flc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tap_count (tap_count),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .result    (result)
  );

  `FLC_ASSERT_NOW(a_full_has_head, clk, rst, item.valid && !item.ready, q_valid, "queue full but head empty")
  `FLC_ASSERT_NEXT(a_push_visible, clk, rst, item.valid && item.ready, q_valid, "accepted beat not queued")
  `FLC_ASSERT_NEXT(a_sample_busy, clk, rst, q_valid && q_ready && q_entry.is_sample, !q_ready, "back end idle after sample")
  `FLC_ASSERT_NEXT(a_pop_no_result, clk, rst, q_valid && q_ready, !$rose(result.valid), "result right after dequeue")
endmodule

### test/full_linear_convolution_unit_tb.sv
// Testbench for full_linear_convolution_unit: loads kernel taps, streams Q16.16 sample
// sequences and checks every output beat against an exact fixed-point convolution model.
// Depends on flc_pkg and the channel interfaces in flc_if.sv.
module full_linear_convolution_unit_tb;
  import flc_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct {
    sample_t value;
    logic    sat;
    logic    last;
  } conv_out_t;

  class conv_scoreboard;
    tap_t       kernel[MAX_TAPS];
    sample_t    history[MAX_TAPS];
    cfg_count_t taps_in_use;
    conv_out_t  expected_q[$];
    int         fail_count;

    function new();
      foreach (kernel[k]) kernel[k] = '0;
      foreach (history[k]) history[k] = '0;
      taps_in_use = 1;
      fail_count  = 0;
    endfunction

    function void set_tap_count(cfg_count_t v);
      taps_in_use = v;
    endfunction

    function int active_taps();
      if (taps_in_use == 0) return 1;
      if (taps_in_use > MAX_TAPS) return MAX_TAPS;
      return int'(taps_in_use);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void shift_in(sample_t s);
      for (int k = MAX_TAPS - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = s;
    endfunction

    function void push_output(bit is_last);
      longint    acc;
      longint    lim;
      conv_out_t o;
      acc = 0;
      lim = longint'(1) <<< 47;
      for (int k = 0; k < active_taps(); k++)
        acc += longint'(kernel[k]) * longint'(history[k]);
      o.last = is_last;
      if (acc >= lim) begin
        o.sat   = 1'b1;
        o.value = SAT_MAX;
      end else if (acc < -lim) begin
        o.sat   = 1'b1;
        o.value = SAT_MIN;
      end else begin
        o.sat   = 1'b0;
        o.value = sample_t'(acc >>> FRAC_BITS);
      end
      expected_q.insert(expected_q.size(), o);
    endfunction

    function void absorb_item(op_t op, tidx_in_t idx, tap_in_t tv, sample_t s, logic last);
      int n;
      if (op == OP_TAP) begin
        kernel[idx] = tap_t'(tv);
        return;
      end
      n = active_taps();
      shift_in(s);
      push_output(last && n == 1);
      if (last) begin
        for (int f = 1; f < n; f++) begin
          shift_in('0);
          push_output(f + 1 == n);
        end
        foreach (history[k]) history[k] = '0;
      end
    endfunction

    function void check_output(sample_t v, logic sat, logic last);
      conv_out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output beat value %0d sat %0b last %0b",
                 $time, v, sat, last);
        fail_count++;
        return;
      end
      e = expected_q.pop_front();
      if (v !== e.value) begin
        $display("%0t: conv_value expected %0d got %0d", $time, e.value, v);
        fail_count++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated expected %0b got %0b", $time, e.sat, sat);
        fail_count++;
      end
      if (last !== e.last) begin
        $display("%0t: last_output expected %0b got %0b", $time, e.last, last);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  int   src_idle_pct;
  int   snk_idle_pct;
  bit   hold_off_req;

  conv_scoreboard sb = new();

  flc_item_if   item_ch ();
  flc_result_if res_ch ();
  flc_cfg_if    cfg_ch ();

  full_linear_convolution_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s = $urandom;
    case ($urandom_range(5))
      0: s = SAT_MAX;
      1: s = SAT_MIN;
      2, 3: s = s >>> 11;
      default: ;
    endcase
    return s;
  endfunction

  function automatic tap_in_t rand_tap();
    case ($urandom_range(7))
      0: return 18'sh1FFFF;
      1: return -18'sd131072;
      default: return tap_in_t'($urandom);
    endcase
  endfunction

  task automatic send_item(op_t op, tidx_in_t idx, tap_in_t tv, sample_t s, logic last);
    int gap;
    item_ch.valid       <= 1'b1;
    item_ch.opcode      <= op;
    item_ch.tap_index   <= idx;
    item_ch.tap_value   <= tv;
    item_ch.sample      <= s;
    item_ch.last_sample <= last;
    do @(posedge clk); while (!item_ch.ready);
    sb.absorb_item(op, idx, tv, s, last);
    if ($urandom_range(99) < src_idle_pct) begin
      gap = pick_gap();
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_tap(tidx_in_t idx, tap_in_t tv);
    send_item(OP_TAP, idx, tv, sample_t'($urandom), logic'($urandom_range(1)));
  endtask

  task automatic send_sample(sample_t s, logic last);
    send_item(OP_SAMPLE, tidx_in_t'($urandom), tap_in_t'($urandom), s, last);
  endtask

  task automatic write_tap_count(cfg_count_t v);
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.tap_count <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_tap_count(v);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready)
        sb.check_output(res_ch.conv_value, res_ch.saturated, res_ch.last_output);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < snk_idle_pct) begin
        stall_left   = pick_gap() - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int   seq_len;
    logic is_last;
    src_idle_pct = 25;
    snk_idle_pct = 25;
    hold_off_req = 1'b0;
    rst                 <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.opcode      <= OP_TAP;
    item_ch.tap_index   <= '0;
    item_ch.tap_value   <= '0;
    item_ch.sample      <= '0;
    item_ch.last_sample <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.tap_count    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_tap(0, 18'sh1FFFF);
    send_sample(SAT_MAX, 1'b0);
    send_sample(SAT_MIN, 1'b0);
    send_sample('0, 1'b1);
    load_tap(0, -18'sd131072);
    send_sample(SAT_MAX, 1'b1);
    send_sample(SAT_MIN, 1'b0);
    load_tap(1, 18'sh10000);
    load_tap(2, -18'sh08000);
    load_tap(3, 18'sd1);
    load_tap(63, 18'sh155AA);
    load_tap(0, 18'sh10000);
    write_tap_count(4);
    send_sample(32'sh0001_0000, 1'b0);
    send_sample(-32'sh0001_0000, 1'b0);
    load_tap(2, 18'sh0C000);
    send_sample(32'sh1234_5678, 1'b1);
    write_tap_count(0);
    send_sample(32'sh0003_0000, 1'b1);

    // fill the whole kernel before any longer tap count
    for (int k = 0; k < MAX_TAPS; k++) load_tap(tidx_in_t'(k), rand_tap());
    write_tap_count(127);
    for (int i = 0; i < 4; i++) send_sample(rand_sample(), i == 3);
    write_tap_count(MAX_TAPS);
    for (int i = 0; i < 3; i++) send_sample(rand_sample(), i == 2);

    // back pressure: stream with no gaps while the result side holds off
    write_tap_count(2);
    src_idle_pct = 0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 14; i++) send_sample(rand_sample(), i == 13);

    for (int ph = 0; ph < 2; ph++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: write_tap_count(cfg_count_t'($urandom_range(1, 8)));
        6, 7: write_tap_count(cfg_count_t'($urandom_range(9, 40)));
        default: write_tap_count(cfg_count_t'($urandom_range(0, 127)));
      endcase
      src_idle_pct = ($urandom_range(2) == 0) ? 0 : 30;
      snk_idle_pct = ($urandom_range(2) == 0) ? 0 : 30;
      seq_len = 0;
      for (int i = 0; i < 13; i++) begin
        if ($urandom_range(5) == 0) begin
          load_tap(tidx_in_t'($urandom), rand_tap());
        end else if ($urandom_range(19) == 0) begin
          send_sample(rand_sample(), logic'($urandom_range(1)));
        end else begin
          seq_len++;
          is_last = (seq_len >= $urandom_range(1, 6));
          if (is_last) seq_len = 0;
          send_sample(rand_sample(), is_last);
        end
      end
    end

    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
